/* hdl/tws_pkg.sv */
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants of the window statistics core
// Field widths, command codes and the packed layout of one result transaction.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int RAW_W    = 16;
  localparam int VAL_W    = 17;
  localparam int OFF_W    = 18;
  localparam int NUM_AXES = 3;
  localparam int MODE_W   = 2;

  // Command codes carried in tuser; the spare code behaves as a plain sample
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WINDOW = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd2;

  // One result transaction, value_x in the lowest bits
  typedef struct packed {
    logic signed [VAL_W-1:0] mean_z;
    logic signed [VAL_W-1:0] max_z;
    logic signed [VAL_W-1:0] min_z;
    logic signed [VAL_W-1:0] mean_y;
    logic signed [VAL_W-1:0] max_y;
    logic signed [VAL_W-1:0] min_y;
    logic signed [VAL_W-1:0] mean_x;
    logic signed [VAL_W-1:0] max_x;
    logic signed [VAL_W-1:0] min_x;
    logic signed [VAL_W-1:0] value_z;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_x;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;
  localparam int IN_W     = NUM_AXES * RAW_W;

endpackage

/* hdl/three_axis_window_statistics_core.sv */
// ----------------------------------------------------------------------------
// three_axis_window_statistics_core: per-axis offset, sliding window statistics
// Offset correction with 17-bit saturation, window store, min/max/mean.
// ----------------------------------------------------------------------------
// Takes one three-axis sample per transaction and returns one result with the
// corrected values and the held min, max and truncated mean of each axis.
// A sample or zero command passes from the idle state to the finish state, where
// it waits for the output register to be free. A window sample also passes the
// write, walk and divide states: the walk reads one window row per cycle through
// the single read port of the store, over the fill entries present after the
// write, and one shared serial divider then forms the three means one after
// another. The input is accepted
// only while the sequencer is idle; a finished result waits in the output
// register without holding back the next input. The window store needs no
// clearing after reset, since only rows already written are read.
module three_axis_window_statistics_core
  import tws_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // raw_x, raw_y, raw_z
  input  logic [MODE_W-1:0] s_axis_tuser,   // mode
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // value_x/y/z, min/max/mean x, y, z
);

  localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int SW    = VAL_W + FW;
  localparam int ROW_W = NUM_AXES * VAL_W;
  localparam int SAT_W = OFF_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WRITE  = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic signed [OFF_W-1:0] offset   [NUM_AXES];
  logic signed [VAL_W-1:0] cur      [NUM_AXES];
  logic signed [VAL_W-1:0] corr     [NUM_AXES];
  logic signed [VAL_W-1:0] min_h    [NUM_AXES];
  logic signed [VAL_W-1:0] max_h    [NUM_AXES];
  logic signed [VAL_W-1:0] mean_h   [NUM_AXES];
  logic signed [SW-1:0]    sum      [NUM_AXES];
  logic signed [VAL_W-1:0] row_val  [NUM_AXES];

  logic [FW-1:0] fill;
  logic [AW-1:0] oldest;
  logic [FW-1:0] rd_idx;
  logic          rd_pend;
  logic          rd_first;
  logic [1:0]    axis;
  logic          div_go;
  logic          div_neg;
  logic          div_done;
  logic [SW-1:0] div_q;
  logic [SW-1:0] div_mag;
  logic signed [SW-1:0] div_signed;

  logic             full;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;
  logic             s_accept;
  logic             out_load;
  result_t          result;

  // Offset correction and saturation to 17 bits
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [RAW_W-1:0] raw,
    input logic signed [OFF_W-1:0] off
  );
    logic signed [SAT_W-1:0] s;
    s = SAT_W'(raw) + SAT_W'(off);
    if (s < -(SAT_W'(1) <<< (VAL_W - 1))) begin
      sat_add = {1'b1, {(VAL_W-1){1'b0}}};
    end else if (s > (SAT_W'(1) <<< (VAL_W - 1)) - SAT_W'(1)) begin
      sat_add = {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_add = s[VAL_W-1:0];
    end
  endfunction

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      corr[a]    = sat_add(s_axis_tdata[a*RAW_W +: RAW_W], offset[a]);
      row_val[a] = ram_rdata[a*VAL_W +: VAL_W];
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // Window store: one row holds the three axes of one sample
  assign full      = (fill == FW'(WINDOW_DEPTH));
  assign ram_we    = (state == ST_WRITE);
  assign ram_waddr = full ? oldest : fill[AW-1:0];
  assign ram_wdata = {cur[2], cur[1], cur[0]};

  tws_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Shared divider for the three means
  assign div_mag = sum[axis][SW-1] ? SW'(-sum[axis]) : SW'(sum[axis]);

  tws_divider #(
    .DW (SW),
    .VW (FW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_mag),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_signed = div_neg ? -$signed(div_q) : $signed(div_q);

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      oldest <= '0;
      rd_idx <= '0;
      rd_pend <= 1'b0;
      div_go <= 1'b0;
      axis   <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        offset[a] <= '0;
        cur[a]    <= '0;
        min_h[a]  <= '0;
        max_h[a]  <= '0;
        mean_h[a] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser == MODE_ZERO) begin
              for (int a = 0; a < NUM_AXES; a++) begin
                offset[a] <= -OFF_W'(cur[a]);
              end
              state <= ST_FINISH;
            end else begin
              for (int a = 0; a < NUM_AXES; a++) begin
                cur[a] <= corr[a];
              end
              state <= (s_axis_tuser == MODE_WINDOW) ? ST_WRITE : ST_FINISH;
            end
          end
        end
        ST_WRITE: begin
          // Overwrite the oldest row once full, else append
          if (full) begin
            oldest <= (oldest == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest + 1'b1;
          end else begin
            fill <= fill + 1'b1;
          end
          rd_idx  <= '0;
          rd_pend <= 1'b0;
          state   <= ST_WALK;
        end
        ST_WALK: begin
          // Present rows always sit at addresses 0 .. fill-1
          if (rd_idx != fill) begin
            rd_idx  <= rd_idx + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              if (rd_first || row_val[a] < min_h[a]) min_h[a] <= row_val[a];
              if (rd_first || row_val[a] > max_h[a]) max_h[a] <= row_val[a];
            end
          end
          if (rd_idx == fill && !rd_pend) begin
            axis   <= '0;
            div_go <= 1'b1;
            state  <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          div_go <= 1'b0;
          if (div_done) begin
            mean_h[axis] <= div_signed[VAL_W-1:0];
            if (axis == 2'(NUM_AXES - 1)) begin
              state <= ST_FINISH;
            end else begin
              axis   <= axis + 1'b1;
              div_go <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Running sums and first-row flag of the walk, and sign of the divided sum
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      rd_first <= 1'b1;
    end else if (state == ST_WALK && rd_pend) begin
      rd_first <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        sum[a] <= (rd_first ? '0 : sum[a]) + SW'(row_val[a]);
      end
    end
    if (div_go) begin
      div_neg <= sum[axis][SW-1];
    end
  end

  // Result assembly
  always_comb begin
    result.value_x = cur[0];
    result.value_y = cur[1];
    result.value_z = cur[2];
    result.min_x   = min_h[0];
    result.max_x   = max_h[0];
    result.mean_x  = mean_h[0];
    result.min_y   = min_h[1];
    result.max_y   = max_h[1];
    result.mean_y  = mean_h[1];
    result.min_z   = min_h[2];
    result.max_z   = max_h[2];
    result.mean_z  = mean_h[2];
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= OUT_W'(result);
    end
  end

endmodule

/* hdl/tws_ram.sv */
// ----------------------------------------------------------------------------
// tws_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tws_divider.sv */
// ----------------------------------------------------------------------------
// tws_divider: shared restoring divider
// Unsigned quotient, one bit per cycle; done pulses as the last quotient bit is shifted in.
// ----------------------------------------------------------------------------
module tws_divider #(
  parameter int DW = 24,
  parameter int VW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_shift;
  logic          fits;

  // Trial subtract of one quotient bit
  assign rem_shift = {rem, quotient[DW-1]};
  assign fits      = rem_shift >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? VW'(rem_shift - {1'b0, dvs}) : rem_shift[VW-1:0];
      quotient <= {quotient[DW-2:0], fits};
    end
  end

endmodule

/* hdl/tws_checker.sv */
// ----------------------------------------------------------------------------
// tws_checker: port-level checks of the window statistics core
// Watches the stream ports and flags ordering or value slips.
// ----------------------------------------------------------------------------
module tws_checker
  import tws_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata
);

  result_t r;

  assign r = m_axis_tdata[RESULT_W-1:0];

  // Sequencer goes busy straight after taking a transaction
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while sequencer busy");

  // A stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Window minimum never exceeds the maximum
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (r.min_x <= r.max_x) && (r.min_y <= r.max_y) && (r.min_z <= r.max_z))
    else $error("window min above max");

  // Truncated mean lies between minimum and maximum
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (r.min_x <= r.mean_x) && (r.mean_x <= r.max_x) &&
                      (r.min_y <= r.mean_y) && (r.mean_y <= r.max_y) &&
                      (r.min_z <= r.mean_z) && (r.mean_z <= r.max_z))
    else $error("window mean outside min/max");

endmodule

bind three_axis_window_statistics_core tws_checker u_tws_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
